// File: hw/rtl/lsfh_pkg.sv
package lsfh_pkg;

  localparam logic [7:0] SyncByte = 8'h55;
  localparam logic [7:0] ChecksumOk = 8'hFF;
  localparam logic [7:0] LedIdReset = 8'hC1;
  localparam logic [7:0] ButtonIdReset = 8'h42;

  localparam int CfgIndexW = 2;
  localparam logic [CfgIndexW-1:0] CfgLedFrameId = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgButtonFrameId = 2'd1;

  localparam logic KindLedDuty = 1'b0;
  localparam logic KindTxByte = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_break;
    logic       button_pressed;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Results produced by one processed byte: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } emit_t;

  typedef enum logic [4:0] {
    PH_WAIT_BREAK = 5'b00001,
    PH_WAIT_SYNC  = 5'b00010,
    PH_WAIT_PID   = 5'b00100,
    PH_WAIT_DATA  = 5'b01000,
    PH_WAIT_CKSUM = 5'b10000
  } phase_t;

  // Add two bytes with end-around carry.
  function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

// File: hw/rtl/lin_slave_frame_handler_unit.sv
// Path: input stage register, then result queue. Throughput: 1 byte per cycle while
//   the queue has room for two results; a button frame header yields two results,
//   which leave the 4-entry result queue at one per cycle unless result_stall holds.
// Reset (rst, synchronous, active high): frame phase to waiting for break,
//   frame IDs to 0xC1 / 0x42, input stage and result queue emptied.
module lin_slave_frame_handler_unit import lsfh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int QueueDepth = 4;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  // Configuration registers: always ready; write them only while no request
  // is in flight.
  logic [7:0] led_frame_id;
  logic [7:0] button_frame_id;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_frame_id    <= LedIdReset;
      button_frame_id <= ButtonIdReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgLedFrameId:    led_frame_id    <= cfg_data;
        CfgButtonFrameId: button_frame_id <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: hold one request; advance it only when the queue has room
  // for the two results a byte may cause.
  logic              stage_valid;
  item_t             stage_item;
  logic              stage_go;
  logic              item_take;
  logic [CountW-1:0] queue_count;

  assign stage_go   = stage_valid && (queue_count <= CountW'(QueueDepth - 2));
  assign item_stall = stage_valid && !stage_go;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= item_take || (stage_valid && !stage_go);
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      stage_item <= item;
    end
  end

  // Frame decode: phase tracking and checksum work in one pass.
  emit_t emit;

  lsfh_frame_ctrl u_frame_ctrl (
    .clk             (clk),
    .rst             (rst),
    .step            (stage_go),
    .item            (stage_item),
    .led_frame_id    (led_frame_id),
    .button_frame_id (button_frame_id),
    .emit            (emit)
  );

  // Result queue: push up to two results per cycle, drop one per taken result.
  result_t           queue_mem [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [1:0]        push_count;
  logic              pop;
  logic [CountW-1:0] queue_count_next;

  assign push_count   = stage_go ? emit.count : 2'd0;
  assign result_valid = (queue_count != '0);
  assign pop          = result_valid && !result_stall;
  assign result       = queue_mem[rd_ptr];
  assign queue_count_next = queue_count + CountW'(push_count) - CountW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      queue_count <= '0;
    end else begin
      wr_ptr      <= wr_ptr + PtrW'(push_count);
      rd_ptr      <= rd_ptr + PtrW'(pop);
      queue_count <= queue_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue_mem[wr_ptr] <= emit.first;
    end
    if (push_count == 2'd2) begin
      queue_mem[wr_ptr + PtrW'(1)] <= emit.second;
    end
  end

  // Queue never overfills.
  assert property (@(posedge clk) disable iff (rst)
    queue_count <= CountW'(QueueDepth))
    else $error("result queue overfilled");

  // Occupancy follows pushes and pops exactly.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> queue_count == $past(queue_count_next))
    else $error("result queue count slipped");

  // A held request only waits on a queue without room for two results.
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_go |-> queue_count > CountW'(QueueDepth - 2))
    else $error("input stage stalled without cause");

  // LED duty results always close their request.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KindLedDuty |-> result.last)
    else $error("LED duty result not marked last");

endmodule

// File: hw/rtl/lsfh_frame_ctrl.sv
module lsfh_frame_ctrl import lsfh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] led_frame_id,
  input  logic [7:0] button_frame_id,
  output emit_t      emit
);

  phase_t     phase, phase_next;
  logic [7:0] received_data;
  logic [7:0] led_sum;
  logic [7:0] frame_sum;
  logic [7:0] button_sum;
  logic [7:0] button_byte;

  assign button_byte = {7'd0, item.button_pressed};
  assign led_sum     = fold_add(led_frame_id, received_data);
  assign frame_sum   = fold_add(led_sum, item.rx_byte);
  assign button_sum  = fold_add(item.rx_byte, button_byte);

  always_comb begin
    phase_next = PH_WAIT_BREAK;
    emit       = '0;
    if (item.rx_break) begin
      phase_next = (item.rx_byte == 8'd0) ? PH_WAIT_SYNC : PH_WAIT_BREAK;
    end else begin
      unique case (phase)
        PH_WAIT_SYNC: begin
          phase_next = (item.rx_byte == SyncByte) ? PH_WAIT_PID : PH_WAIT_BREAK;
        end
        PH_WAIT_PID: begin
          if (item.rx_byte == led_frame_id) begin
            phase_next = PH_WAIT_DATA;
          end else if (item.rx_byte == button_frame_id) begin
            emit.count  = 2'd2;
            emit.first  = '{kind: KindTxByte, value: button_byte, last: 1'b0};
            emit.second = '{kind: KindTxByte, value: ~button_sum, last: 1'b1};
          end
        end
        PH_WAIT_DATA: begin
          phase_next = PH_WAIT_CKSUM;
        end
        PH_WAIT_CKSUM: begin
          if (frame_sum == ChecksumOk) begin
            emit.count = 2'd1;
            emit.first = '{kind: KindLedDuty, value: received_data, last: 1'b1};
          end
        end
        default: begin
          phase_next = PH_WAIT_BREAK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT_BREAK;
      received_data <= 8'd0;
    end else if (step) begin
      phase <= phase_next;
      if (!item.rx_break && phase == PH_WAIT_DATA) begin
        received_data <= item.rx_byte;
      end
    end
  end

endmodule
